/* sv/bsc_pkg.sv */
package bsc_pkg;

  // One quotient bit is resolved per divider cell.
  localparam int DivSteps = 64;

  // Configuration register indexes.
  localparam logic [1:0] CFG_TEMP_CAL = 2'd0;
  localparam logic [1:0] CFG_PRESS_A  = 2'd1;
  localparam logic [1:0] CFG_PRESS_B  = 2'd2;
  localparam logic [1:0] CFG_PRESS_C  = 2'd3;

  // Calibration words; all but t1 and p1 are two's complement.
  typedef struct packed {
    logic [15:0] t1;
    logic [15:0] t2;
    logic [15:0] t3;
    logic [15:0] p1;
    logic [15:0] p2;
    logic [15:0] p3;
    logic [15:0] p4;
    logic [15:0] p5;
    logic [15:0] p6;
    logic [15:0] p7;
    logic [15:0] p8;
    logic [15:0] p9;
  } bsc_cal_t;

  // Per-item control that rides along with the arithmetic.
  typedef struct packed {
    logic        vld;
    logic [31:0] temp;
    logic        pvalid;
  } bsc_side_t;

  // Contents of one divider cell.
  typedef struct packed {
    bsc_side_t   side;
    logic        qneg;
    logic [30:0] dmag;
    logic [30:0] rem;
    logic [63:0] nq;
  } bsc_div_t;

endpackage

/* sv/barometric_sample_compensation.sv */
// Channel | Direction | Handshake            | Payload
// in      | input     | in_valid / in_ready  | raw_temperature, raw_pressure
// out     | output    | out_valid/out_ready  | temperature_centi, pressure_q24_8,
//         |           |                      | pressure_valid
// cfg     | input     | cfg_valid/cfg_ready  | cfg_index, cfg_data
//
// One item is accepted per cycle while no result is held at the output.
// The pipeline is 9 front stages, a row of 64 divider cells and 5 back stages.
// Reset (rst_n low at a clock edge) empties the pipeline and clears calibration.
// A held result stalls the whole pipeline in place; in_ready drops with it.
// Configuration writes are always taken.
module barometric_sample_compensation import bsc_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [19:0]        in_raw_temperature,
  input  logic [19:0]        in_raw_pressure,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_temperature_centi,
  output logic [31:0]        out_pressure_q24_8,
  output logic               out_pressure_valid,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [63:0]        cfg_data
);

  // Calibration registers as the host writes them.
  logic [47:0] temp_cal_r;
  logic [63:0] press_a_r;
  logic [63:0] press_b_r;
  logic [15:0] press_c_r;

  bsc_cal_t cal;
  bsc_div_t div_head, div_tail;
  logic     en;

  // The whole pipeline advances together unless a finished result is held.
  assign en        = !out_valid || out_ready;
  assign in_ready  = en;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      temp_cal_r <= '0;
      press_a_r  <= '0;
      press_b_r  <= '0;
      press_c_r  <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_TEMP_CAL: temp_cal_r <= cfg_data[47:0];
        CFG_PRESS_A:  press_a_r  <= cfg_data;
        CFG_PRESS_B:  press_b_r  <= cfg_data;
        CFG_PRESS_C:  press_c_r  <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // Unpack the twelve sensor calibration words.
  always_comb begin
    cal.t1 = temp_cal_r[15:0];
    cal.t2 = temp_cal_r[31:16];
    cal.t3 = temp_cal_r[47:32];
    cal.p1 = press_a_r[15:0];
    cal.p2 = press_a_r[31:16];
    cal.p3 = press_a_r[47:32];
    cal.p4 = press_a_r[63:48];
    cal.p5 = press_b_r[15:0];
    cal.p6 = press_b_r[31:16];
    cal.p7 = press_b_r[47:32];
    cal.p8 = press_b_r[63:48];
    cal.p9 = press_c_r;
  end

  // Temperature, fine temperature and the pressure numerator and divisor.
  bsc_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .en              (en),
    .in_valid        (in_valid),
    .raw_temperature (in_raw_temperature),
    .raw_pressure    (in_raw_pressure),
    .cal             (cal),
    .head            (div_head)
  );

  // Long division, one quotient bit per cell.
  bsc_div_row u_div_row (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .head  (div_head),
    .tail  (div_tail)
  );

  // Quadratic pressure correction and the output register.
  bsc_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .en                (en),
    .tail              (div_tail),
    .cal               (cal),
    .out_valid         (out_valid),
    .temperature_centi (out_temperature_centi),
    .pressure_q24_8    (out_pressure_q24_8),
    .pressure_valid    (out_pressure_valid)
  );

  // A result flagged invalid always carries zero pressure.
  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_pressure_valid |-> out_pressure_q24_8 == 32'd0)
    else $error("invalid pressure result is not zero");

  // While stalled, the divider input does not move.
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(div_head.nq) && $stable(div_head.dmag))
    else $error("divider input changed during a stall");

  // Reset leaves no result pending.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result pending after reset");

  // A stalled result keeps its pressure.
  a_held_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_pressure_q24_8) && out_valid)
    else $error("held result changed");

endmodule

/* sv/bsc_div_cell.sv */
module bsc_div_cell import bsc_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     en,
  input  bsc_div_t d_in,
  output bsc_div_t d_out
);

  bsc_div_t    cell_r;
  bsc_div_t    cell_nxt;
  logic [31:0] trial;
  logic        ge;

  // One restoring step: shift in the next numerator bit, subtract if it fits.
  always_comb begin
    trial    = {d_in.rem, d_in.nq[63]};
    ge       = trial >= {1'b0, d_in.dmag};
    cell_nxt = d_in;
    cell_nxt.rem = ge ? 31'(trial - {1'b0, d_in.dmag}) : trial[30:0];
    cell_nxt.nq  = {d_in.nq[62:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) cell_r.side.vld <= 1'b0;
    else if (en) cell_r <= cell_nxt;
  end

  assign d_out = cell_r;

endmodule

/* sv/bsc_div_row.sv */
module bsc_div_row import bsc_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     en,
  input  bsc_div_t head,
  output bsc_div_t tail
);

  bsc_div_t link [DivSteps+1];

  assign link[0] = head;

  for (genvar i = 0; i < DivSteps; i++) begin : g_cell
    bsc_div_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .d_in  (link[i]),
      .d_out (link[i+1])
    );
  end

  assign tail = link[DivSteps];

endmodule

/* sv/bsc_front.sv */
module bsc_front import bsc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        en,
  input  logic        in_valid,
  input  logic [19:0] raw_temperature,
  input  logic [19:0] raw_pressure,
  input  bsc_cal_t    cal,
  output bsc_div_t    head
);

  localparam logic signed [63:0] Bias47 = 64'sd140737488355328;

  logic [7:0] vld_r;

  logic signed [17:0] ta;
  logic signed [16:0] tb;
  logic signed [25:0] pv1;
  logic signed [27:0] tmp5;
  logic signed [72:0] mp1_full;
  logic signed [76:0] num_full;

  logic signed [33:0] at2_r, bsq_r;
  logic signed [22:0] v1t_r;
  logic signed [37:0] bt3_r;
  logic signed [24:0] fine_r;
  logic signed [51:0] v1sq_r;
  logic signed [41:0] m5_r, m2_r;
  logic signed [62:0] m6_r, m3_r;
  logic signed [63:0] v2part_r, v1part_r, v2_r;
  logic signed [55:0] x_r;
  logic [63:0]        diff_r, mp1_r, num_r;
  logic signed [30:0] dv_r;
  logic [20:0]        pp1_r, pp2_r, pp3_r, pp4_r, pp5_r, pp6_r;
  logic [31:0]        temp4_r, temp5_r, temp6_r, temp7_r, temp8_r;
  bsc_div_t           head_r, head_nxt;

  always_comb begin
    ta   = $signed({1'b0, raw_temperature[19:3]}) - $signed({1'b0, cal.t1, 1'b0});
    tb   = $signed({1'b0, raw_temperature[19:4]}) - $signed({1'b0, cal.t1});
    pv1  = 26'(fine_r) - 26'sd128000;
    tmp5 = 28'(fine_r) * 28'sd5 + 28'sd128;
    mp1_full = x_r * $signed({1'b0, cal.p1});
    num_full = $signed(diff_r) * $signed(13'd3125);
  end

  // Sign and magnitude split ahead of the unsigned divider row.
  always_comb begin
    head_nxt             = '0;
    head_nxt.side.vld    = vld_r[7];
    head_nxt.side.temp   = temp8_r;
    head_nxt.side.pvalid = dv_r != 31'sd0;
    head_nxt.qneg        = num_r[63] ^ dv_r[30];
    head_nxt.dmag        = dv_r[30] ? 31'(~dv_r + 31'sd1) : dv_r;
    head_nxt.rem         = '0;
    head_nxt.nq          = num_r[63] ? (~num_r + 64'd1) : num_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[6:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      at2_r <= ta * $signed(cal.t2);
      bsq_r <= tb * tb;
      pp1_r <= 21'(21'h100000 - {1'b0, raw_pressure});

      v1t_r <= at2_r[33:11];
      bt3_r <= $signed({1'b0, bsq_r[32:12]}) * $signed(cal.t3);
      pp2_r <= pp1_r;

      fine_r <= 25'(v1t_r) + 25'($signed(bt3_r[37:14]));
      pp3_r  <= pp2_r;

      temp4_r <= 32'($signed(tmp5[27:8]));
      v1sq_r  <= pv1 * pv1;
      m5_r    <= pv1 * $signed(cal.p5);
      m2_r    <= pv1 * $signed(cal.p2);
      pp4_r   <= pp3_r;

      temp5_r  <= temp4_r;
      m6_r     <= $signed(v1sq_r[46:0]) * $signed(cal.p6);
      m3_r     <= $signed(v1sq_r[46:0]) * $signed(cal.p3);
      v2part_r <= (64'(m5_r) <<< 17) + (64'($signed(cal.p4)) <<< 35);
      v1part_r <= 64'(m2_r) <<< 12;
      pp5_r    <= pp4_r;

      temp6_r <= temp5_r;
      v2_r    <= 64'(m6_r) + v2part_r;
      x_r     <= 56'((64'(m3_r) >>> 8) + v1part_r + Bias47);
      pp6_r   <= pp5_r;

      temp7_r <= temp6_r;
      diff_r  <= 64'({pp6_r, 31'b0}) - v2_r;
      mp1_r   <= mp1_full[63:0];

      temp8_r <= temp7_r;
      num_r   <= num_full[63:0];
      dv_r    <= mp1_r[63:33];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) head_r.side.vld <= 1'b0;
    else if (en) head_r <= head_nxt;
  end

  assign head = head_r;

endmodule

/* sv/bsc_back.sv */
module bsc_back import bsc_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  bsc_div_t           tail,
  input  bsc_cal_t           cal,
  output logic               out_valid,
  output logic signed [31:0] temperature_centi,
  output logic [31:0]        pressure_q24_8,
  output logic               pressure_valid
);

  logic [3:0]  vld_r;
  logic [31:0] temp_r [4];
  logic [3:0]  pv_r;
  logic        out_vld_r;
  logic [31:0] out_temp_r, out_press_r;
  logic        out_pv_r;

  logic signed [63:0] q1_r, q2_r, q3_r, q4_r;
  logic signed [63:0] xs;
  logic [63:0]        xlxl_r, sq_r;
  logic [30:0]        xlxh_r;
  logic [63:0]        m8_r, m9_r;
  logic signed [63:0] v2_3_r, v2_4_r;
  logic signed [79:0] m8_full, m9_full;
  logic signed [63:0] sum, res;

  always_comb begin
    xs      = q1_r >>> 13;
    m8_full = q1_r * $signed(cal.p8);
    m9_full = $signed(sq_r) * $signed(cal.p9);
    sum     = q4_r + ($signed(m9_r) >>> 25) + v2_4_r;
    res     = (sum >>> 8) + (64'($signed(cal.p7)) <<< 4);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r     <= '0;
      out_vld_r <= 1'b0;
    end else if (en) begin
      vld_r     <= {vld_r[2:0], tail.side.vld};
      out_vld_r <= vld_r[3];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      temp_r[0] <= tail.side.temp;
      temp_r[1] <= temp_r[0];
      temp_r[2] <= temp_r[1];
      temp_r[3] <= temp_r[2];
      pv_r      <= {pv_r[2:0], tail.side.pvalid};

      q1_r <= tail.qneg ? $signed(~tail.nq + 64'd1) : $signed(tail.nq);

      // Square of q >>> 13 modulo 2^64 from two 32-bit partial products.
      xlxl_r <= xs[31:0] * xs[31:0];
      xlxh_r <= 31'(xs[31:0] * xs[63:32]);
      m8_r   <= m8_full[63:0];
      q2_r   <= q1_r;

      sq_r   <= xlxl_r + {xlxh_r, 33'b0};
      v2_3_r <= $signed(m8_r) >>> 19;
      q3_r   <= q2_r;

      m9_r   <= m9_full[63:0];
      v2_4_r <= v2_3_r;
      q4_r   <= q3_r;

      out_temp_r  <= temp_r[3];
      out_pv_r    <= pv_r[3];
      out_press_r <= pv_r[3] ? res[31:0] : 32'd0;
    end
  end

  assign out_valid         = out_vld_r;
  assign temperature_centi = $signed(out_temp_r);
  assign pressure_q24_8    = out_press_r;
  assign pressure_valid    = out_pv_r;

endmodule

/* tb/sv/tb_barometric_sample_compensation.sv */
module tb_barometric_sample_compensation import bsc_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  // The drain wait after the last expected result is sized from the pipeline
  // latency below; the idle limit of the watchdog is set on its own.
  localparam int PipeLatency = 78;
  localparam int DrainCycles = 2 * PipeLatency;
  localparam int IdleLimit   = 20000;

  // One compensated reading as the output channel carries it.
  typedef struct {
    logic signed [31:0] temp_centi;
    logic [31:0]        press_q24_8;
    logic               press_ok;
  } reading_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [19:0]        in_raw_temperature = '0;
  logic [19:0]        in_raw_pressure = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [31:0] out_temperature_centi;
  logic [31:0]        out_pressure_q24_8;
  logic               out_pressure_valid;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [1:0]         cfg_index = CFG_TEMP_CAL;
  logic [63:0]        cfg_data = '0;

  // The testbench's own copy of the four calibration registers.
  logic [47:0] cal_temp;
  logic [63:0] cal_press_a;
  logic [63:0] cal_press_b;
  logic [15:0] cal_press_c;

  reading_t expected_readings[$];
  int       mismatch_count = 0;
  int       idle_cycles = 0;

  // Idle controls: percentages of cycles in which each side holds back, and a
  // long receiver hold-off counted down in its own process.
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned recv_holdoff = 0;

  always #4 clk = ~clk;

  barometric_sample_compensation u_dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_raw_temperature   (in_raw_temperature),
    .in_raw_pressure      (in_raw_pressure),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_temperature_centi(out_temperature_centi),
    .out_pressure_q24_8   (out_pressure_q24_8),
    .out_pressure_valid   (out_pressure_valid),
    .cfg_valid            (cfg_valid),
    .cfg_ready            (cfg_ready),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data)
  );

  // Sign-extends one 16-bit calibration word to 64 bits.
  function automatic logic [63:0] widen_word(input logic [15:0] w);
    return {{48{w[15]}}, w};
  endfunction

  // Arithmetic shift right of a 64-bit two's complement word.
  function automatic logic [63:0] shift_down(input logic [63:0] x, input int n);
    return $unsigned($signed(x) >>> n);
  endfunction

  // Integer compensation of one temperature and pressure pair. Every step is
  // done on 64-bit words that wrap, shifts round toward minus infinity and the
  // one division truncates toward zero.
  function automatic reading_t compensate(input logic [19:0] adc_t,
                                          input logic [19:0] adc_p);
    reading_t    r;
    logic [63:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
    logic [63:0] a, b, v1, v2, fine, temp, p, num, mn, md, q;
    t1 = {48'd0, cal_temp[15:0]};
    t2 = widen_word(cal_temp[31:16]);
    t3 = widen_word(cal_temp[47:32]);
    p1 = {48'd0, cal_press_a[15:0]};
    p2 = widen_word(cal_press_a[31:16]);
    p3 = widen_word(cal_press_a[47:32]);
    p4 = widen_word(cal_press_a[63:48]);
    p5 = widen_word(cal_press_b[15:0]);
    p6 = widen_word(cal_press_b[31:16]);
    p7 = widen_word(cal_press_b[47:32]);
    p8 = widen_word(cal_press_b[63:48]);
    p9 = widen_word(cal_press_c);

    a = {44'd0, adc_t} >> 3;
    a = a - (t1 << 1);
    v1 = shift_down(a * t2, 11);
    b = ({44'd0, adc_t} >> 4) - t1;
    v2 = shift_down(shift_down(b * b, 12) * t3, 14);
    fine = v1 + v2;
    temp = shift_down(fine * 64'd5 + 64'd128, 8);

    v1 = fine - 64'd128000;
    v2 = v1 * v1 * p6;
    v2 = v2 + ((v1 * p5) << 17);
    v2 = v2 + (p4 << 35);
    v1 = shift_down(v1 * v1 * p3, 8) + ((v1 * p2) << 12);
    v1 = shift_down(((64'd1 << 47) + v1) * p1, 33);
    r.press_ok = 1'b1;
    if (v1 == 64'd0) begin
      p = 64'd0;
      r.press_ok = 1'b0;
    end else begin
      p = 64'd1048576 - {44'd0, adc_p};
      num = ((p << 31) - v2) * 64'd3125;
      mn = num[63] ? -num : num;
      md = v1[63] ? -v1 : v1;
      q = mn / md;
      p = (num[63] != v1[63]) ? -q : q;
      v1 = shift_down(p9 * shift_down(p, 13) * shift_down(p, 13), 25);
      v2 = shift_down(p8 * p, 19);
      p = shift_down(p + v1 + v2, 8) + (p7 << 4);
    end
    r.temp_centi = temp[31:0];
    r.press_q24_8 = p[31:0];
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("MISMATCH %s: got 0x%0h, expected 0x%0h at %0t", what, got, want, $realtime);
    mismatch_count++;
  endtask

  // Writes one calibration register and updates the local copy with it.
  // Valid stays high so that writes can follow each other directly.
  task automatic write_calibration(input logic [1:0] idx, input logic [63:0] value);
    cfg_index <= idx;
    cfg_data  <= value;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_TEMP_CAL: cal_temp = value[47:0];
      CFG_PRESS_A:  cal_press_a = value;
      CFG_PRESS_B:  cal_press_b = value;
      default:      cal_press_c = value[15:0];
    endcase
    @(negedge clk);
  endtask

  task automatic load_calibration(input logic [47:0] tc, input logic [63:0] pa,
                                  input logic [63:0] pb, input logic [15:0] pc);
    write_calibration(CFG_TEMP_CAL, {16'd0, tc});
    write_calibration(CFG_PRESS_A, pa);
    write_calibration(CFG_PRESS_B, pb);
    write_calibration(CFG_PRESS_C, {48'd0, pc});
    cfg_valid <= 1'b0;
  endtask

  // Offers one reading pair, after an optional random gap, and records what
  // the block should answer once the item is taken. Valid stays high across
  // back-to-back items, so it is only lowered when a gap follows.
  task automatic send_reading(input logic [19:0] adc_t, input logic [19:0] adc_p);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_raw_temperature <= adc_t;
    in_raw_pressure    <= adc_p;
    in_valid           <= 1'b1;
    do @(posedge clk); while (!in_ready);
    expected_readings.push_back(compensate(adc_t, adc_p));
    @(negedge clk);
  endtask

  // Lowers valid and waits until every reading sent so far has come back,
  // then lets the pipeline drain before anything else is changed.
  task automatic wait_for_drain();
    in_valid <= 1'b0;
    while (expected_readings.size() != 0) @(negedge clk);
    repeat (DrainCycles) @(negedge clk);
  endtask

  // A plausible factory calibration with T1, T2, P1 and P9 randomized within
  // their usual span.
  task automatic load_typical_calibration();
    load_calibration({16'hFC18, 16'h6600 + 16'($urandom_range(2047)),
                      16'd27000 + 16'($urandom_range(2000))},
                     {16'd2800, 16'd36, 16'hD5D0, 16'd36000 + 16'($urandom_range(2000))},
                     {16'h1770, 16'hFFF9, 16'hFFF9, 16'd140},
                     16'(int'($urandom_range(2000)) - 1000));
  endtask

  task automatic send_random_pair();
    send_reading(20'($urandom), 20'($urandom));
  endtask

  // Extremes of both readings and of every calibration word, and the zero
  // divisor case, which the reset calibration (P1 = 0) already gives.
  task automatic test_directed();
    send_reading(20'h00000, 20'h00000);
    send_reading(20'hFFFFF, 20'hFFFFF);
    wait_for_drain();
    load_typical_calibration();
    send_reading(20'h00000, 20'h00000);
    send_reading(20'hFFFFF, 20'hFFFFF);
    send_reading(20'h7E000, 20'h50000);
    send_reading(20'h80000, 20'hAAAAA);
    send_reading(20'h55555, 20'h55555);
    wait_for_drain();
    // Largest and most negative words, where the intermediates wrap.
    load_calibration(48'h7FFF_7FFF_FFFF, 64'h7FFF_7FFF_7FFF_FFFF,
                     64'h7FFF_7FFF_7FFF_7FFF, 16'h7FFF);
    send_reading(20'hFFFFF, 20'h00000);
    send_reading(20'h00000, 20'hFFFFF);
    send_reading(20'h12345, 20'h6789A);
    wait_for_drain();
    load_calibration(48'h8000_8000_0000, 64'h8000_8000_8000_0001,
                     64'h8000_8000_8000_8000, 16'h8000);
    send_reading(20'hFFFFF, 20'hFFFFF);
    send_reading(20'h00000, 20'h00000);
    send_reading(20'h3C3C3, 20'hC3C3C);
    wait_for_drain();
    // P1 = 0 with everything else set forces the zero divisor again.
    load_calibration(48'h6500_6500_6B00, 64'hD5D0_D5D0_0024_0000,
                     64'h008C_FFF9_FFF9_1770, 16'h1770);
    send_reading(20'h7E000, 20'h50000);
    send_reading(20'hFFFFF, 20'h00001);
    wait_for_drain();
  endtask

  // Random readings under typical and fully random calibration in turn, in several idling phases.
  task automatic test_random_phases();
    int unsigned phase;
    for (phase = 0; phase < 4; phase++) begin
      if (phase[0]) begin
        load_calibration({$urandom, 16'($urandom)}, {$urandom, $urandom},
                         {$urandom, $urandom}, 16'($urandom));
      end else begin
        load_typical_calibration();
      end
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 51; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 51; end
        default: begin send_idle_pct = 8; recv_stall_pct = 8; end
      endcase
      repeat (160) begin
        // Most pairs lie near the usual operating span of the converter.
        if ($urandom_range(3) != 0) begin
          send_reading(20'h60000 + 20'($urandom_range(20'h3FFFF)),
                       20'h30000 + 20'($urandom_range(20'h5FFFF)));
        end else begin
          send_random_pair();
        end
      end
      wait_for_drain();
    end
    send_idle_pct = 0;
    recv_stall_pct = 0;
  endtask

  // The receiver holds off for a long stretch while items keep coming, so the
  // pipeline fills and in_ready drops; then a burst runs with no idling.
  task automatic test_backpressure();
    load_typical_calibration();
    recv_holdoff = 300;
    repeat (100) send_random_pair();
    wait_for_drain();
  endtask

  // Result checker: each accepted reading is compared with the oldest one
  // still expected.
  always @(posedge clk) begin
    reading_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_readings.size() == 0) begin
        report_mismatch("unexpected item", {32'd0, out_pressure_q24_8}, 64'd0);
      end else begin
        want = expected_readings.pop_front();
        if (out_temperature_centi !== want.temp_centi)
          report_mismatch("temperature_centi", {32'd0, out_temperature_centi},
                          {32'd0, want.temp_centi});
        if (out_pressure_q24_8 !== want.press_q24_8)
          report_mismatch("pressure_q24_8", {32'd0, out_pressure_q24_8},
                          {32'd0, want.press_q24_8});
        if (out_pressure_valid !== want.press_ok)
          report_mismatch("pressure_valid", {63'd0, out_pressure_valid},
                          {63'd0, want.press_ok});
      end
    end
  end

  // Receiver ready, driven at the falling edge from the stall settings.
  always @(negedge clk) begin
    if (recv_holdoff != 0) begin
      recv_holdoff <= recv_holdoff - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Watchdog: counts cycles in which no item moves on any channel.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IdleLimit) begin
      $display("Watchdog expired with %0d items outstanding", expected_readings.size());
      $display("** barometric_sample_compensation: FAILED **");
      $finish;
    end
  end

  initial begin
    cal_temp = '0;
    cal_press_a = '0;
    cal_press_b = '0;
    cal_press_c = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_directed();
    test_random_phases();
    test_backpressure();
    wait_for_drain();
    if (mismatch_count == 0) begin
      $display("** barometric_sample_compensation: PASSED **");
    end else begin
      $display("** barometric_sample_compensation: FAILED **");
    end
    $finish;
  end

endmodule
